@@ src/ptts_pkg.sv @@
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared constants, codes and types of the periodic tick scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ptts_pkg;

   // table geometry
   localparam int NUM_SLOTS   = 8;
   localparam int COUNT_WIDTH = 16;

   localparam int SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int WALK_W      = $clog2(NUM_SLOTS + 1);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request codes on req_type
   localparam logic [2:0] REQ_TICK    = 3'd0;
   localparam logic [2:0] REQ_CREATE  = 3'd1;
   localparam logic [2:0] REQ_DELETE  = 3'd2;
   localparam logic [2:0] REQ_SUSPEND = 3'd3;
   localparam logic [2:0] REQ_RESUME  = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_STATUS   = 2'd0;
   localparam logic [1:0] KIND_DISPATCH = 2'd1;
   localparam logic [1:0] KIND_DONE     = 2'd2;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_CREATE,
      OP_DELETE,
      OP_SUSPEND,
      OP_RESUME,
      OP_BAD
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [2:0]              slot;      // as received, echoed in replies
      logic                    slot_ok;   // slot below NUM_SLOTS
      logic [SLOT_IDX_W-1:0]   slot_idx;
      logic [COUNT_WIDTH-1:0]  period;
      logic [COUNT_WIDTH-1:0]  delay;     // zero already forced to one
   } cmd_type;

endpackage

`default_nettype wire

@@ src/periodic_task_tick_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_top
// Time-triggered cooperative tick scheduler: a table of periodic task slots
// counted down by tick requests, with create, delete, suspend and resume.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   req     | in        | req_valid/req_stall| req_type, req_slot, req_period,
//           |           |                    | req_first_delay
//   rsp     | out       | rsp_valid/rsp_stall| rsp_result_kind, rsp_task_index,
//           |           |                    | rsp_status, rsp_last
//
// A command item gives one status item. A tick item is handled in order: pop,
// then one slot per cycle while no result waits under rsp_stall, then the done
// marker; the back end walks the slot table in ascending slot order.
// A two-entry queue lets the front take items while the back end is busy.
// Synchronous reset clears the slot table (all slots free), queue and output.
// While a result item waits under rsp_stall the back end holds its walk; no
// item is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_tick_scheduler_top (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [2:0]   req_type,
   input  wire logic [2:0]   req_slot,
   input  wire logic [15:0]  req_period,
   input  wire logic [15:0]  req_first_delay,
   // result channel
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [1:0]        rsp_result_kind,
   output logic [2:0]        rsp_task_index,
   output logic              rsp_status,
   output logic              rsp_last
);

   // decoded command handed from front to back
   logic               cmd_valid;
   logic               cmd_pop;
   ptts_pkg::cmd_type  cmd;

   // front: decode each item (op, slot range check, period cut, first
   // delay of zero taken as one) and queue it
   ptts_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_slot        (req_slot),
      .req_period      (req_period),
      .req_first_delay (req_first_delay),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   // back: owns the slot table; executes commands, walks slots on a tick
   // and drives the registered result stage
   ptts_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_task_index  (rsp_task_index),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

@@ src/ptts_front.sv @@
// ----------------------------------------------------------------------------
// ptts_front
// Request decode and a short command queue feeding the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [2:0]           req_type,
   input  wire logic [2:0]           req_slot,
   input  wire logic [15:0]          req_period,
   input  wire logic [15:0]          req_first_delay,
   output logic                      cmd_valid,
   output ptts_pkg::cmd_type         cmd,
   input  wire logic                 cmd_pop
);

   ptts_pkg::cmd_type                       entry_ff [ptts_pkg::QUEUE_DEPTH];
   logic [ptts_pkg::QPTR_W-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [ptts_pkg::QPTR_W-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [ptts_pkg::QCNT_W-1:0]             count_ff, count_in;
   ptts_pkg::cmd_type                       dec;
   logic [ptts_pkg::COUNT_WIDTH-1:0]        dly_cut;
   logic                                    push;
   logic                                    pop;

   // decode
   always_comb begin
      dly_cut = ptts_pkg::COUNT_WIDTH'(req_first_delay);
      unique case (req_type)
         ptts_pkg::REQ_TICK:    dec.op = ptts_pkg::OP_TICK;
         ptts_pkg::REQ_CREATE:  dec.op = ptts_pkg::OP_CREATE;
         ptts_pkg::REQ_DELETE:  dec.op = ptts_pkg::OP_DELETE;
         ptts_pkg::REQ_SUSPEND: dec.op = ptts_pkg::OP_SUSPEND;
         ptts_pkg::REQ_RESUME:  dec.op = ptts_pkg::OP_RESUME;
         default:               dec.op = ptts_pkg::OP_BAD;
      endcase
      dec.slot     = req_slot;
      dec.slot_ok  = (32'(req_slot) < 32'(ptts_pkg::NUM_SLOTS));
      dec.slot_idx = ptts_pkg::SLOT_IDX_W'(req_slot);
      dec.period   = ptts_pkg::COUNT_WIDTH'(req_period);
      dec.delay    = (dly_cut == '0) ? ptts_pkg::COUNT_WIDTH'(1) : dly_cut;
   end

   assign req_stall = (count_ff == ptts_pkg::QCNT_W'(ptts_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == ptts_pkg::QUEUE_DEPTH - 1) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == ptts_pkg::QUEUE_DEPTH - 1) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

`default_nettype wire

@@ src/ptts_back.sv @@
// ----------------------------------------------------------------------------
// ptts_back
// Slot table, tick walk and command execution with a registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_valid,
   input  wire ptts_pkg::cmd_type    cmd,
   output logic                      cmd_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_result_kind,
   output logic [2:0]                rsp_task_index,
   output logic                      rsp_status,
   output logic                      rsp_last
);

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   localparam int N  = ptts_pkg::NUM_SLOTS;
   localparam int CW = ptts_pkg::COUNT_WIDTH;

   state_type                        state_ff, state_in;
   logic [ptts_pkg::WALK_W-1:0]      walk_ff, walk_in;
   logic [CW-1:0]                    period_ff [N];
   logic [CW-1:0]                    period_in [N];
   logic [CW-1:0]                    count_ff  [N];
   logic [CW-1:0]                    count_in  [N];
   logic                             susp_ff   [N];
   logic                             susp_in   [N];

   logic                             valid_ff, valid_in;
   logic [1:0]                       kind_ff, kind_in;
   logic [2:0]                       index_ff, index_in;
   logic                             status_ff, status_in;
   logic                             last_ff, last_in;

   logic                             out_free;
   logic [ptts_pkg::SLOT_IDX_W-1:0]  widx;
   logic [ptts_pkg::SLOT_IDX_W-1:0]  sidx;
   logic                             active;
   logic                             err;

   assign out_free = !valid_ff || !rsp_stall;
   assign widx     = walk_ff[ptts_pkg::SLOT_IDX_W-1:0];
   assign sidx     = cmd.slot_idx;

   always_comb begin
      state_in  = state_ff;
      walk_in   = walk_ff;
      period_in = period_ff;
      count_in  = count_ff;
      susp_in   = susp_ff;
      kind_in   = kind_ff;
      index_in  = index_ff;
      status_in = status_ff;
      last_in   = last_ff;
      valid_in  = valid_ff && rsp_stall;
      cmd_pop   = 1'b0;
      active    = 1'b0;
      err       = ptts_pkg::STATUS_ERR;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               if (cmd.op == ptts_pkg::OP_TICK) begin
                  state_in = ST_WALK;
                  walk_in  = '0;
               end else begin
                  if (cmd.slot_ok) begin
                     active = (period_ff[sidx] != '0);
                     unique case (cmd.op)
                        ptts_pkg::OP_CREATE: begin
                           if (!active) begin
                              if (cmd.period != '0) begin
                                 period_in[sidx] = cmd.period;
                                 count_in[sidx]  = cmd.delay;
                                 susp_in[sidx]   = 1'b0;
                              end
                              err = ptts_pkg::STATUS_OK;
                           end
                        end
                        ptts_pkg::OP_DELETE: begin
                           if (active) begin
                              period_in[sidx] = '0;
                              err = ptts_pkg::STATUS_OK;
                           end
                        end
                        ptts_pkg::OP_SUSPEND: begin
                           if (active && !susp_ff[sidx]) begin
                              susp_in[sidx] = 1'b1;
                              err = ptts_pkg::STATUS_OK;
                           end
                        end
                        ptts_pkg::OP_RESUME: begin
                           if (active && susp_ff[sidx]) begin
                              susp_in[sidx] = 1'b0;
                              err = ptts_pkg::STATUS_OK;
                           end
                        end
                        default: err = ptts_pkg::STATUS_ERR;
                     endcase
                  end
                  valid_in  = 1'b1;
                  kind_in   = ptts_pkg::KIND_STATUS;
                  index_in  = cmd.slot;
                  status_in = err;
                  last_in   = 1'b1;
               end
            end
         end
         ST_WALK: begin
            if (out_free) begin
               if (walk_ff == ptts_pkg::WALK_W'(N)) begin
                  valid_in  = 1'b1;
                  kind_in   = ptts_pkg::KIND_DONE;
                  index_in  = '0;
                  status_in = ptts_pkg::STATUS_OK;
                  last_in   = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  walk_in = walk_ff + 1'b1;
                  if (period_ff[widx] != '0) begin
                     if (count_ff[widx] <= CW'(1)) begin
                        count_in[widx] = period_ff[widx];
                        if (!susp_ff[widx]) begin
                           valid_in  = 1'b1;
                           kind_in   = ptts_pkg::KIND_DISPATCH;
                           index_in  = 3'(walk_ff);
                           status_in = ptts_pkg::STATUS_OK;
                           last_in   = 1'b0;
                        end
                     end else begin
                        count_in[widx] = count_ff[widx] - 1'b1;
                     end
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         walk_ff   <= '0;
         valid_ff  <= 1'b0;
         for (int i = 0; i < N; i++) begin
            period_ff[i] <= '0;
            count_ff[i]  <= '0;
            susp_ff[i]   <= 1'b0;
         end
      end else begin
         state_ff  <= state_in;
         walk_ff   <= walk_in;
         valid_ff  <= valid_in;
         period_ff <= period_in;
         count_ff  <= count_in;
         susp_ff   <= susp_in;
      end
      kind_ff   <= kind_in;
      index_ff  <= index_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_task_index  = index_ff;
   assign rsp_status      = status_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the periodic task tick scheduler.
// A directed opener covers the corner cases first: empty ticks, zero first
// delay, zero period, busy and free slots, double suspend and resume, and
// unknown request codes. Random requests follow, mostly ticks and creates
// with short periods so that dispatches are frequent. A slot-table tracker
// predicts every result item and checks each one as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ptts_pkg::*;

   // request codes above REQ_RESUME are not defined and must give an error
   localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
   localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

   // settle time after the last result; a tick walks every slot, then a done marker
   localparam int DRAIN_CYCLES = 4 * (NUM_SLOTS + 2);

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] task_idx;
      logic       status;
      logic       last;
   } sched_rsp_type;

   // -------------------------------------------------------------------------
   // Tracker: own copy of the slot table. note_request() is called once per
   // accepted request item and queues the items it must produce;
   // check_result() pops the oldest one and compares it field by field.
   // -------------------------------------------------------------------------
   class dispatch_tracker;
      logic [COUNT_WIDTH-1:0] reload_q [NUM_SLOTS];
      logic [COUNT_WIDTH-1:0] count_q  [NUM_SLOTS];
      bit                     held_q   [NUM_SLOTS];
      sched_rsp_type          due_results [$];
      int                     mismatch_count;

      function new();
         for (int i = 0; i < NUM_SLOTS; i++) begin
            reload_q[i] = '0;
            count_q[i]  = '0;
            held_q[i]   = 1'b0;
         end
         mismatch_count = 0;
      endfunction

      function void queue_item(logic [1:0] kind, logic [2:0] idx, logic st, logic lst);
         sched_rsp_type item;
         item.kind     = kind;
         item.task_idx = idx;
         item.status   = st;
         item.last     = lst;
         due_results.push_back(item);
      endfunction

      function void note_request(logic [2:0] rtype, logic [2:0] slot,
                                 logic [15:0] per, logic [15:0] dly);
         logic [COUNT_WIDTH-1:0] per_c;
         logic [COUNT_WIDTH-1:0] dly_c;
         logic                   active;
         logic                   st;
         int                     i;
         per_c = per[COUNT_WIDTH-1:0];
         dly_c = dly[COUNT_WIDTH-1:0];
         if (rtype == REQ_TICK) begin
            // ascending walk; free slots keep their countdown untouched
            for (i = 0; i < NUM_SLOTS; i++) begin
               if (reload_q[i] == '0) continue;
               if (count_q[i] <= 1) begin
                  count_q[i] = reload_q[i];
                  if (!held_q[i]) queue_item(KIND_DISPATCH, 3'(i), STATUS_OK, 1'b0);
               end else begin
                  count_q[i] = count_q[i] - 1'b1;
               end
            end
            queue_item(KIND_DONE, 3'd0, STATUS_OK, 1'b1);
            return;
         end
         st = STATUS_ERR;
         if (int'(slot) < NUM_SLOTS) begin
            i      = int'(slot);
            active = (reload_q[i] != '0);
            case (rtype)
               REQ_CREATE: begin
                  if (!active) begin
                     if (per_c != '0) begin
                        reload_q[i] = per_c;
                        count_q[i]  = (dly_c == '0) ? COUNT_WIDTH'(1) : dly_c;
                        held_q[i]   = 1'b0;
                     end
                     st = STATUS_OK;
                  end
               end
               REQ_DELETE: begin
                  if (active) begin
                     reload_q[i] = '0;
                     st          = STATUS_OK;
                  end
               end
               REQ_SUSPEND: begin
                  if (active && !held_q[i]) begin
                     held_q[i] = 1'b1;
                     st        = STATUS_OK;
                  end
               end
               REQ_RESUME: begin
                  if (active && held_q[i]) begin
                     held_q[i] = 1'b0;
                     st        = STATUS_OK;
                  end
               end
               default: ;
            endcase
         end
         queue_item(KIND_STATUS, slot, st, 1'b1);
      endfunction

      function void check_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_result(sched_rsp_type got);
         sched_rsp_type want;
         if (due_results.size() == 0) begin
            $display({"%0t: unexpected item, expected none, ",
                      "actual kind %0d index %0d status %0d last %0d"},
                     $time, got.kind, got.task_idx, got.status, got.last);
            mismatch_count++;
            return;
         end
         want = due_results.pop_front();
         check_field("result_kind", want.kind, got.kind);
         check_field("task_index", want.task_idx, got.task_idx);
         check_field("status", want.status, got.status);
         check_field("last", want.last, got.last);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT signals; every input has a known value from time zero
   // -------------------------------------------------------------------------
   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [2:0]  req_type        = REQ_TICK;
   logic [2:0]  req_slot        = 3'd0;
   logic [15:0] req_period      = 16'd0;
   logic [15:0] req_first_delay = 16'd0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [2:0]  rsp_task_index;
   logic        rsp_status;
   logic        rsp_last;

   // idle rates in percent, changed between phases by the stimulus process
   int req_idle_pct = 13;
   int rsp_idle_pct = 74;

   dispatch_tracker tracker = new();

   periodic_task_tick_scheduler_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_slot        (req_slot),
      .req_period      (req_period),
      .req_first_delay (req_first_delay),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_task_index  (rsp_task_index),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Result side: sample the handshake as it stood just before the edge, then
   // pick the stall for the next cycle. One nonblocking write per edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_result({rsp_result_kind, rsp_task_index, rsp_status, rsp_last});
      end
      rsp_stall <= (32'($urandom_range(99)) < 32'(rsp_idle_pct));
   end

   // -------------------------------------------------------------------------
   // Request side. valid is left high after an accepted item; the next call
   // either drops it for an idle gap or loads the next payload straight away,
   // so valid never gets two writes in one step.
   // -------------------------------------------------------------------------
   task automatic send_request(input logic [2:0] rtype, input logic [2:0] slot,
                               input logic [15:0] per, input logic [15:0] dly);
      if (32'($urandom_range(99)) < 32'(req_idle_pct)) begin
         req_valid <= 1'b0;
         do @(posedge clock);
         while (32'($urandom_range(99)) < 32'(req_idle_pct));
      end
      req_valid       <= 1'b1;
      req_type        <= rtype;
      req_slot        <= slot;
      req_period      <= per;
      req_first_delay <= dly;
      // req_stall read here is the value the block saw at this edge
      do @(posedge clock);
      while (req_stall);
      tracker.note_request(rtype, slot, per, dly);
   endtask

   // Random requests: ticks dominate, creates mostly use short periods and
   // delays so slots fire often; now and then full-width values and zero
   // periods, plus a few undefined request codes as noise.
   task automatic run_random(input int count);
      logic [2:0]  rtype;
      logic [2:0]  slot;
      logic [15:0] per;
      logic [15:0] dly;
      int          roll;
      repeat (count) begin
         roll = $urandom_range(99);
         if (roll < 45)      rtype = REQ_TICK;
         else if (roll < 65) rtype = REQ_CREATE;
         else if (roll < 75) rtype = REQ_DELETE;
         else if (roll < 85) rtype = REQ_SUSPEND;
         else if (roll < 95) rtype = REQ_RESUME;
         else                rtype = 3'($urandom_range(REQ_UNKNOWN_HI, REQ_UNKNOWN_LO));
         slot = 3'($urandom_range(7));
         roll = $urandom_range(99);
         if (roll < 80)      per = 16'($urandom_range(6, 1));
         else if (roll < 88) per = 16'd0;
         else                per = 16'($urandom);
         roll = $urandom_range(99);
         if (roll < 85) dly = 16'($urandom_range(7));
         else           dly = 16'($urandom);
         send_request(rtype, slot, per, dly);
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // --- directed opener, under the first idle setting ---
      send_request(REQ_TICK,    3'd0, 16'd0,      16'd0);      // empty table: done only
      send_request(REQ_CREATE,  3'd0, 16'd1,      16'd0);      // zero first delay counts as one
      send_request(REQ_CREATE,  3'd0, 16'd4,      16'd4);      // busy slot: error
      send_request(REQ_CREATE,  3'd1, 16'd0,      16'd9);      // zero period: ok, stays free
      send_request(REQ_CREATE,  3'd7, 16'hFFFF,   16'hFFFF);   // widest period and delay
      send_request(REQ_CREATE,  3'd2, 16'd2,      16'd3);
      send_request(REQ_TICK,    3'd0, 16'd0,      16'd0);      // slot 0 fires
      send_request(REQ_SUSPEND, 3'd0, 16'd0,      16'd0);
      send_request(REQ_SUSPEND, 3'd0, 16'd0,      16'd0);      // already suspended
      send_request(REQ_TICK,    3'd0, 16'd0,      16'd0);      // slot 0 reloads silently
      send_request(REQ_RESUME,  3'd0, 16'd0,      16'd0);
      send_request(REQ_RESUME,  3'd0, 16'd0,      16'd0);      // already running
      send_request(REQ_SUSPEND, 3'd1, 16'd0,      16'd0);      // free slot
      send_request(REQ_RESUME,  3'd3, 16'd0,      16'd0);      // free slot
      send_request(REQ_DELETE,  3'd4, 16'd0,      16'd0);      // free slot
      send_request(REQ_TICK,    3'd0, 16'd0,      16'd0);      // slots 0 and 2 fire
      send_request(REQ_SUSPEND, 3'd2, 16'd0,      16'd0);
      send_request(REQ_DELETE,  3'd2, 16'd0,      16'd0);      // delete while suspended
      send_request(REQ_TICK,    3'd0, 16'd0,      16'd0);      // deleted slot skipped
      send_request(REQ_UNKNOWN_LO, 3'd5, 16'h5555, 16'hAAAA);
      send_request(REQ_UNKNOWN_HI, 3'd6, 16'hAAAA, 16'h5555);
      send_request(REQ_CREATE,  3'd2, 16'd1,      16'h8000);   // re-create comes up running
      send_request(REQ_CREATE,  3'd6, 16'd3,      16'd1);
      send_request(REQ_TICK,    3'd0, 16'd0,      16'd0);
      send_request(REQ_DELETE,  3'd7, 16'd0,      16'd0);

      // --- random part in three idle settings ---
      run_random(35);
      req_idle_pct = 74;
      rsp_idle_pct = 13;
      run_random(35);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(35);
      req_valid <= 1'b0;

      // drain, then allow a full tick walk for stray items
      while (tracker.due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.mismatch_count == 0 && tracker.due_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (about 130 items, each up to
   // nine result items under heavy stall)
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
